>>> hw/rtl/pwg_pkg.sv
package pwg_pkg;

    localparam int PHASE_BITS         = 16;
    localparam int SAMPLE_BITS        = 16;
    localparam int SINE_TABLE_ENTRIES = 256;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    typedef enum logic [2:0] {
        FUNC_SINE     = 3'd0,
        FUNC_COSINE   = 3'd1,
        FUNC_RAMP     = 3'd2,
        FUNC_SAW      = 3'd3,
        FUNC_TRIANGLE = 3'd4,
        FUNC_SQUARE   = 3'd5
    } pwg_func_t;

    typedef struct packed {
        logic valid;
        logic tri_wave;
    } pwg_ctrl_t;

    // Sine of an angle in Q30 radians by a Taylor series, rounded to the sample scale.
    function automatic logic [31:0] sine_entry(input logic [63:0] angle,
                                               input int unsigned sample_bits);
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic [63:0]        fs;
        logic [63:0]        v;
        x2   = (angle * angle) >> 30;
        term = angle;
        sum  = signed'(angle);
        term = ((term * x2) >> 30) / 64'd6;
        sum  = sum - signed'(term);
        term = ((term * x2) >> 30) / 64'd20;
        sum  = sum + signed'(term);
        term = ((term * x2) >> 30) / 64'd42;
        sum  = sum - signed'(term);
        term = ((term * x2) >> 30) / 64'd72;
        sum  = sum + signed'(term);
        term = ((term * x2) >> 30) / 64'd110;
        sum  = sum - signed'(term);
        term = ((term * x2) >> 30) / 64'd156;
        sum  = sum + signed'(term);
        term = ((term * x2) >> 30) / 64'd210;
        sum  = sum - signed'(term);
        term = ((term * x2) >> 30) / 64'd272;
        sum  = sum + signed'(term);
        if (sum < 0)
        begin
            sum = 64'sd0;
        end
        fs = 64'd1 << (sample_bits - 1);
        v  = ((unsigned'(sum) * fs) + (64'd1 << 29)) >> 30;
        if (v > fs - 64'd1)
        begin
            v = fs - 64'd1;
        end
        return v[31:0];
    endfunction

endpackage

>>> hw/rtl/periodic_waveform_generator_unit.sv
// Takes one request (phase and waveform select) in every clock cycle; busy is never raised,
// and the sample appears on sample with done high once it has passed the front register, the
// division cells and the output register. The pipeline's length is set by the triangle's
// division, done by a row of SAMPLE_BITS + 1 restoring-division cells, one quotient bit per
// cell; every other waveform travels through the same row so that samples leave in request
// order. There is no back-pressure: the receiver must take each sample in the cycle in which
// done is high. The pulse width may be written at any time the unit holds no request.
module periodic_waveform_generator_unit #(
    parameter int PHASE_BITS         = pwg_pkg::PHASE_BITS,
    parameter int SAMPLE_BITS        = pwg_pkg::SAMPLE_BITS,
    parameter int SINE_TABLE_ENTRIES = pwg_pkg::SINE_TABLE_ENTRIES
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [PHASE_BITS-1:0]         phase,
    input  logic [2:0]                    func,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [PHASE_BITS-1:0]         cfg_data,
    output logic                          done,
    output logic signed [SAMPLE_BITS-1:0] sample
);

    localparam int CELLS = SAMPLE_BITS + 1;
    localparam int LATENCY = CELLS + 2;
    localparam logic [PHASE_BITS-1:0] PW_RESET = PHASE_BITS'(1) << (PHASE_BITS - 1);
    localparam logic [SAMPLE_BITS-1:0] POS_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};

    logic [PHASE_BITS-1:0]  pulse_width_reg;
    logic                   done_reg, done_next;
    logic [SAMPLE_BITS-1:0] sample_reg, sample_next;

    pwg_pkg::pwg_ctrl_t     ctrl_chain [0:CELLS];
    logic [PHASE_BITS+1:0]  rem_chain  [0:CELLS];
    logic [PHASE_BITS:0]    den_chain  [0:CELLS];
    logic [SAMPLE_BITS:0]   quot_chain [0:CELLS];
    logic [SAMPLE_BITS-1:0] smp_chain  [0:CELLS];

    assign busy       = 1'b0;
    assign cfg_ready  = 1'b1;
    assign quot_chain[0] = '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pulse_width_reg <= PW_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            pulse_width_reg <= cfg_data;
        end
    end

    pwg_front #(
        .PHASE_BITS         (PHASE_BITS),
        .SAMPLE_BITS        (SAMPLE_BITS),
        .SINE_TABLE_ENTRIES (SINE_TABLE_ENTRIES)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (start && !busy),
        .phase       (phase),
        .func        (func),
        .pulse_width (pulse_width_reg),
        .ctrl        (ctrl_chain[0]),
        .num         (rem_chain[0]),
        .den         (den_chain[0]),
        .smp         (smp_chain[0])
    );

    for (genvar i = 0; i < CELLS; i++)
    begin : g_cell
        pwg_div_cell #(
            .PHASE_BITS  (PHASE_BITS),
            .SAMPLE_BITS (SAMPLE_BITS)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl_in  (ctrl_chain[i]),
            .rem_in   (rem_chain[i]),
            .den_in   (den_chain[i]),
            .quot_in  (quot_chain[i]),
            .smp_in   (smp_chain[i]),
            .ctrl_out (ctrl_chain[i+1]),
            .rem_out  (rem_chain[i+1]),
            .den_out  (den_chain[i+1]),
            .quot_out (quot_chain[i+1]),
            .smp_out  (smp_chain[i+1])
        );
    end

    always_comb
    begin
        done_next   = ctrl_chain[CELLS].valid;
        sample_next = smp_chain[CELLS];
        if (ctrl_chain[CELLS].tri_wave)
        begin
            if (quot_chain[CELLS][SAMPLE_BITS])
            begin
                sample_next = POS_MAX;
            end
            else
            begin
                sample_next = {~quot_chain[CELLS][SAMPLE_BITS-1],
                               quot_chain[CELLS][SAMPLE_BITS-2:0]};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sample_reg <= sample_next;
    end

    assign done   = done_reg;
    assign sample = signed'(sample_reg);

    // A finished triangle quotient never exceeds two full scales.
    a_quot_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl_chain[CELLS].valid && ctrl_chain[CELLS].tri_wave && quot_chain[CELLS][SAMPLE_BITS])
        |-> (quot_chain[CELLS][SAMPLE_BITS-1:0] == '0))
        else $error("triangle quotient above two full scales");

    // The final remainder is below twice the divisor.
    a_final_rem: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl_chain[CELLS].valid && ctrl_chain[CELLS].tri_wave)
        |-> (rem_chain[CELLS] < {den_chain[CELLS], 1'b0}))
        else $error("final remainder out of range");

    // Every sample answers an earlier request that has passed through the whole pipeline.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LATENCY))
        else $error("sample without a matching request");

endmodule

>>> hw/rtl/pwg_front.sv
module pwg_front #(
    parameter int PHASE_BITS         = pwg_pkg::PHASE_BITS,
    parameter int SAMPLE_BITS        = pwg_pkg::SAMPLE_BITS,
    parameter int SINE_TABLE_ENTRIES = pwg_pkg::SINE_TABLE_ENTRIES
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    input  logic [PHASE_BITS-1:0]   phase,
    input  logic [2:0]              func,
    input  logic [PHASE_BITS-1:0]   pulse_width,
    output pwg_pkg::pwg_ctrl_t      ctrl,
    output logic [PHASE_BITS+1:0]   num,
    output logic [PHASE_BITS:0]     den,
    output logic [SAMPLE_BITS-1:0]  smp
);

    localparam int IW = $clog2(SINE_TABLE_ENTRIES + 1);
    localparam int QW = PHASE_BITS - 2;
    localparam int MW = QW + IW;
    localparam logic [PHASE_BITS-1:0] QUARTER = PHASE_BITS'(1) << (PHASE_BITS - 2);
    localparam logic [PHASE_BITS:0]   FULL    = (PHASE_BITS + 1)'(1) << PHASE_BITS;
    localparam logic [SAMPLE_BITS-1:0] POS_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic [SAMPLE_BITS-1:0] NEG_MAX = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam int W = PHASE_BITS + SAMPLE_BITS;

    logic [SAMPLE_BITS-1:0] sine_rom [0:SINE_TABLE_ENTRIES];

    for (genvar k = 0; k <= SINE_TABLE_ENTRIES; k++)
    begin : g_rom
        localparam logic [63:0] ANGLE =
            (pwg_pkg::HALF_PI_Q30 * 64'(k)) / 64'(SINE_TABLE_ENTRIES);
        assign sine_rom[k] = SAMPLE_BITS'(pwg_pkg::sine_entry(ANGLE, SAMPLE_BITS));
    end

    pwg_pkg::pwg_ctrl_t     ctrl_reg, ctrl_next;
    logic [PHASE_BITS+1:0]  num_reg, num_next;
    logic [PHASE_BITS:0]    den_reg, den_next;
    logic [SAMPLE_BITS-1:0] smp_reg, smp_next;

    logic [PHASE_BITS-1:0]  sine_arg;
    logic [MW-1:0]          prod;
    logic [IW-1:0]          idx;
    logic [IW-1:0]          rom_idx;
    logic [SAMPLE_BITS-1:0] rom_val;
    logic [SAMPLE_BITS-1:0] sine_val;
    logic [W-1:0]           ramp_w;
    logic [W-1:0]           saw_w;
    logic [SAMPLE_BITS-1:0] saw_s;
    logic                   rise;
    logic [PHASE_BITS:0]    num_w;
    logic [PHASE_BITS:0]    den_w;

    always_comb
    begin
        sine_arg = (pwg_pkg::pwg_func_t'(func) == pwg_pkg::FUNC_COSINE) ?
                   phase + QUARTER : phase;
        prod     = MW'(sine_arg[QW-1:0]) * MW'(SINE_TABLE_ENTRIES);
        idx      = prod[QW +: IW];
        rom_idx  = sine_arg[PHASE_BITS-2] ? (IW'(SINE_TABLE_ENTRIES) - idx) : idx;
        rom_val  = sine_rom[rom_idx];
        sine_val = sine_arg[PHASE_BITS-1] ? (-rom_val) : rom_val;

        ramp_w = W'(phase) << (SAMPLE_BITS - 1);
        saw_w  = W'(phase) << SAMPLE_BITS;
        saw_s  = saw_w[W-1:PHASE_BITS];

        rise  = phase < pulse_width;
        num_w = rise ? {1'b0, phase} : FULL - {1'b0, phase};
        den_w = rise ? {1'b0, pulse_width} : FULL - {1'b0, pulse_width};

        ctrl_next.valid    = in_valid;
        ctrl_next.tri_wave = 1'b0;
        num_next           = {1'b0, num_w};
        den_next           = den_w;
        smp_next           = '0;
        case (pwg_pkg::pwg_func_t'(func))
            pwg_pkg::FUNC_SINE,
            pwg_pkg::FUNC_COSINE:   smp_next = sine_val;
            pwg_pkg::FUNC_RAMP:     smp_next = ramp_w[W-1:PHASE_BITS];
            pwg_pkg::FUNC_SAW:      smp_next = {~saw_s[SAMPLE_BITS-1], saw_s[SAMPLE_BITS-2:0]};
            pwg_pkg::FUNC_TRIANGLE: ctrl_next.tri_wave = 1'b1;
            pwg_pkg::FUNC_SQUARE:   smp_next = rise ? POS_MAX : NEG_MAX;
            default:                smp_next = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '0;
        end
        else
        begin
            ctrl_reg <= ctrl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        den_reg <= den_next;
        smp_reg <= smp_next;
    end

    assign ctrl = ctrl_reg;
    assign num  = num_reg;
    assign den  = den_reg;
    assign smp  = smp_reg;

    // A triangle request always divides a value no larger than its divisor.
    a_ratio_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl_reg.valid && ctrl_reg.tri_wave) |-> (num_reg <= {1'b0, den_reg}))
        else $error("triangle numerator exceeds divisor");

endmodule

>>> hw/rtl/pwg_div_cell.sv
module pwg_div_cell #(
    parameter int PHASE_BITS  = pwg_pkg::PHASE_BITS,
    parameter int SAMPLE_BITS = pwg_pkg::SAMPLE_BITS
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  pwg_pkg::pwg_ctrl_t      ctrl_in,
    input  logic [PHASE_BITS+1:0]   rem_in,
    input  logic [PHASE_BITS:0]     den_in,
    input  logic [SAMPLE_BITS:0]    quot_in,
    input  logic [SAMPLE_BITS-1:0]  smp_in,
    output pwg_pkg::pwg_ctrl_t      ctrl_out,
    output logic [PHASE_BITS+1:0]   rem_out,
    output logic [PHASE_BITS:0]     den_out,
    output logic [SAMPLE_BITS:0]    quot_out,
    output logic [SAMPLE_BITS-1:0]  smp_out
);

    pwg_pkg::pwg_ctrl_t     ctrl_reg;
    logic [PHASE_BITS+1:0]  rem_reg, rem_next;
    logic [PHASE_BITS:0]    den_reg;
    logic [SAMPLE_BITS:0]   quot_reg, quot_next;
    logic [SAMPLE_BITS-1:0] smp_reg;
    logic                   ge;
    logic [PHASE_BITS+1:0]  diff;

    always_comb
    begin
        ge        = rem_in >= {1'b0, den_in};
        diff      = ge ? (rem_in - {1'b0, den_in}) : rem_in;
        rem_next  = {diff[PHASE_BITS:0], 1'b0};
        quot_next = {quot_in[SAMPLE_BITS-1:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '0;
        end
        else
        begin
            ctrl_reg <= ctrl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        den_reg  <= den_in;
        quot_reg <= quot_next;
        smp_reg  <= smp_in;
    end

    assign ctrl_out = ctrl_reg;
    assign rem_out  = rem_reg;
    assign den_out  = den_reg;
    assign quot_out = quot_reg;
    assign smp_out  = smp_reg;

    // The partial remainder stays below twice the divisor along the whole chain.
    a_rem_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl_reg.valid && ctrl_reg.tri_wave) |-> (rem_reg < {den_reg, 1'b0}))
        else $error("partial remainder out of range");

    // A triangle divisor is never zero.
    a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl_reg.valid && ctrl_reg.tri_wave) |-> (den_reg != '0))
        else $error("triangle divisor is zero");

endmodule
